[hw/rtl/hqpam_pkg.sv]
// ----------------------------------------------------------------------------
// hqpam_pkg: shared types and helpers for the quad-plane attitude mixer
// Frame and result structs, field widths, register indexes and saturation.
// ----------------------------------------------------------------------------
package hqpam_pkg;

	localparam int CH_W   = 12;
	localparam int ATT_W  = 16;
	localparam int NUM_W  = 24;   // 32*k*(stick-mid), signed
	localparam int DEN_W  = 13;   // stick span, signed
	localparam int QMAG_W = NUM_W - 1;
	localparam int DMAG_W = DEN_W - 1;
	localparam int CNT_W  = $clog2(QMAG_W);
	localparam int ACC_W  = 34;

	localparam logic [2:0] REG_CONTROL_MODE   = 3'd0;
	localparam logic [2:0] REG_ONBOARD_MIXING = 3'd1;
	localparam logic [2:0] REG_STICK_MIN      = 3'd2;
	localparam logic [2:0] REG_STICK_MID      = 3'd3;
	localparam logic [2:0] REG_STICK_MAX      = 3'd4;
	localparam logic [2:0] REG_OUT_MIN        = 3'd5;
	localparam logic [2:0] REG_OUT_MID        = 3'd6;

	typedef struct packed {
		logic [CH_W-1:0]         throttle_pw;
		logic [CH_W-1:0]         aileron_pw;
		logic [CH_W-1:0]         elevator_pw;
		logic [CH_W-1:0]         rudder_pw;
		logic [CH_W-1:0]         rx_arm;
		logic [CH_W-1:0]         autopilot_pw;
		logic signed [ATT_W-1:0] roll_angle;
		logic signed [ATT_W-1:0] pitch_angle;
		logic signed [ATT_W-1:0] roll_dps;
		logic signed [ATT_W-1:0] pitch_dps;
		logic signed [ATT_W-1:0] yaw_dps;
	} in_t;

	typedef struct packed {
		logic [CH_W-1:0] quad_ch1;
		logic [CH_W-1:0] quad_ch2;
		logic [CH_W-1:0] quad_ch3;
		logic [CH_W-1:0] quad_ch4;
		logic [CH_W-1:0] quad_ch5;
		logic [CH_W-1:0] plane_aileron;
		logic [CH_W-1:0] plane_elevator;
		logic [CH_W-1:0] plane_rudder;
	} out_t;

	function automatic logic signed [ACC_W-1:0] clamp_acc(
		input logic signed [ACC_W-1:0] v, input logic signed [ACC_W-1:0] lim);
		logic signed [ACC_W-1:0] r;
		if (v > lim) r = lim;
		else if (v < -lim) r = -lim;
		else r = v;
		return r;
	endfunction

	function automatic logic [CH_W-1:0] sat12(input logic signed [ACC_W-1:0] v);
		logic [CH_W-1:0] r;
		if (v < 0) r = '0;
		else if (v > ACC_W'(4095)) r = '1;
		else r = v[CH_W-1:0];
		return r;
	endfunction

endpackage

[hw/rtl/hybrid_quad_plane_attitude_mixer_unit.sv]
// sequence: after each input transfer, four stick commands pass through one
// shared bit-serial divider, then the two mix states, the result register and
// the output register
// flow: input stalls after each transfer until the result register takes the
// frame's result, longer while both result registers wait on a stalled output
// reset: control and configuration registers return to their defaults, stored motor values clear to zero
// ----------------------------------------------------------------------------
// hybrid_quad_plane_attitude_mixer_unit: quad-plane attitude mixer
// PD stabilize / acro loops, four-motor X mix and airplane servo loops.
// ----------------------------------------------------------------------------
module hybrid_quad_plane_attitude_mixer_unit
	import hqpam_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_addr,
	input  logic [CH_W-1:0]  cfg_data,
	input  logic             in_valid,
	output logic             in_stall,
	input  in_t              in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output out_t             out_data
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DIV_GO = 5'b00010,
		S_DIV_WT = 5'b00100,
		S_MIXA   = 5'b01000,
		S_MIXB   = 5'b10000
	} state_t;

	localparam logic signed [ACC_W-1:0] LIM4 = ACC_W'(8000);
	localparam logic signed [ACC_W-1:0] LIM5 = ACC_W'(16000);

	state_t state_q;
	logic signed [2:0] mode_q;
	logic              mixing_q;
	logic [CH_W-1:0]   smin_q, smid_q, smax_q, omin_q, omid_q;
	logic [CH_W-1:0]   motor_q [4];
	in_t               item_q;
	logic [1:0]        idx_q;
	logic signed [NUM_W-1:0] cmd_q [4];
	logic signed [17:0] dr_q, dp_q, dy_q;
	logic signed [13:0] ail_q;
	logic signed [14:0] ele_q;
	logic              mix_en_q;
	logic              out_pend_q, out_valid_q;
	out_t              res_q, out_q;
	logic              out_move, res_load;

	// divider operand selection
	logic [CH_W-1:0]         stick;
	logic signed [11:0]      k32;
	logic signed [DEN_W-1:0] diff, span;
	logic signed [NUM_W:0]   prod;
	logic                    div_start, div_done;
	logic signed [NUM_W-1:0] div_quot;

	always_comb begin
		unique case (idx_q)
			2'd0: begin stick = item_q.aileron_pw;  k32 = 12'sd960;  end
			2'd1: begin stick = item_q.elevator_pw; k32 = 12'sd960;  end
			2'd2: begin stick = item_q.rudder_pw;   k32 = 12'sd1600; end
			default: begin stick = item_q.aileron_pw; k32 = 12'sd1600; end
		endcase
	end

	assign diff = $signed({1'b0, stick}) - $signed({1'b0, smid_q});
	assign span = $signed({1'b0, smax_q}) - $signed({1'b0, smin_q});
	assign prod = diff * k32;
	assign div_start = (state_q == S_DIV_GO);

	hqpam_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod[NUM_W-1:0]),
		.den    (span),
		.done   (div_done),
		.quot   (div_quot)
	);

	// stage a: loop terms
	logic signed [ACC_W-1:0] r30, p30, y50, r50, roll, pitch, pr, qr, yr;
	logic signed [ACC_W-1:0] s_dy, s_dr, s_dp, s_ail, s_ele;
	logic signed [17:0] a_dr, a_dp, a_dy;
	logic ap_on, stab, mix_en;

	always_comb begin
		r30   = ACC_W'(cmd_q[0]);
		p30   = ACC_W'(cmd_q[1]);
		y50   = ACC_W'(cmd_q[2]);
		r50   = ACC_W'(cmd_q[3]);
		roll  = ACC_W'($signed(item_q.roll_angle));
		pitch = ACC_W'($signed(item_q.pitch_angle));
		pr    = ACC_W'($signed(item_q.roll_dps));
		qr    = ACC_W'($signed(item_q.pitch_dps));
		yr    = ACC_W'($signed(item_q.yaw_dps));
		s_dy  = -clamp_acc(50 * (yr - y50), LIM4);
		s_dr  = -clamp_acc(2 * (roll - r30) + 10 * pr, LIM4);
		s_dp  = clamp_acc(2 * (pitch + p30) + 10 * qr, LIM4);
		s_ail = clamp_acc(10 * (roll - r50) + 2 * pr, LIM4);
		s_ele = clamp_acc(20 * (pitch + p30) + qr, LIM5);
		a_dr  = 18'(($signed({1'b0, item_q.aileron_pw})  - $signed({1'b0, smid_q})) * 16);
		a_dp  = 18'(($signed({1'b0, item_q.elevator_pw}) - $signed({1'b0, smid_q})) * 16);
		a_dy  = 18'(($signed({1'b0, item_q.rudder_pw})   - $signed({1'b0, smid_q})) * 16);
		ap_on = item_q.autopilot_pw > smid_q;
		// negative mode: switch picks minus the mode, only minus one is a loop mode
		if (mode_q < 0) begin
			stab   = ap_on && (mode_q == -3'sd1);
			mix_en = !ap_on || (mode_q == -3'sd1);
		end else begin
			stab   = (mode_q == 3'sd1);
			mix_en = (mode_q == 3'sd0) || (mode_q == 3'sd1);
		end
		mix_en = mix_en && mixing_q;
	end

	// stage b: motor mix and outputs
	logic signed [ACC_W-1:0] t, dr, dp, dy, ail, ele, omid;
	logic [CH_W-1:0] m_new [4];
	out_t res;
	logic armed;

	always_comb begin
		t    = ACC_W'($signed({1'b0, item_q.throttle_pw})) * 16;
		dr   = ACC_W'(dr_q);
		dp   = ACC_W'(dp_q);
		dy   = ACC_W'(dy_q);
		ail  = ACC_W'(ail_q);
		ele  = ACC_W'(ele_q);
		omid = ACC_W'($signed({1'b0, omid_q}));
		if (mix_en_q) begin
			m_new[0] = sat12((t - dr + dp + dy) >>> 4);
			m_new[1] = sat12((t - dr - dp - dy) >>> 4);
			m_new[2] = sat12((t + dr + dp - dy) >>> 4);
			m_new[3] = sat12((t + dr - dp + dy) >>> 4);
		end else begin
			for (int i = 0; i < 4; i++) m_new[i] = motor_q[i];
		end
		armed = item_q.rx_arm > smid_q;
		if (!mixing_q) begin
			res.quad_ch1 = item_q.throttle_pw;
			res.quad_ch2 = item_q.aileron_pw;
			res.quad_ch3 = item_q.elevator_pw;
			res.quad_ch4 = item_q.rudder_pw;
			res.quad_ch5 = item_q.rx_arm;
		end else if (armed) begin
			res.quad_ch1 = m_new[0];
			res.quad_ch2 = m_new[1];
			res.quad_ch3 = m_new[2];
			res.quad_ch4 = m_new[3];
			res.quad_ch5 = item_q.rx_arm;
		end else begin
			res.quad_ch1 = omin_q;
			res.quad_ch2 = omin_q;
			res.quad_ch3 = omin_q;
			res.quad_ch4 = omin_q;
			res.quad_ch5 = omin_q;
		end
		res.plane_aileron  = sat12(((-ail) >>> 4) + omid);
		res.plane_elevator = sat12((ele >>> 5) + omid);
		res.plane_rudder   = sat12((ail >>> 4) + omid);
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= '0;
			mixing_q <= 1'b0;
			smin_q   <= 12'd992;
			smid_q   <= 12'd1504;
			smax_q   <= 12'd2016;
			omin_q   <= 12'd992;
			omid_q   <= 12'd1504;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_CONTROL_MODE:   mode_q   <= cfg_data[2:0];
				REG_ONBOARD_MIXING: mixing_q <= cfg_data[0];
				REG_STICK_MIN:      smin_q   <= cfg_data;
				REG_STICK_MID:      smid_q   <= cfg_data;
				REG_STICK_MAX:      smax_q   <= cfg_data;
				REG_OUT_MIN:        omin_q   <= cfg_data;
				REG_OUT_MID:        omid_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// pending result moves to the output register when that one is free
	assign out_move = out_pend_q && (!out_valid_q || !out_stall);
	assign res_load = (state_q == S_MIXB) && (!out_pend_q || out_move);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			out_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 4; i++) motor_q[i] <= '0;
		end else begin
			if (out_move) out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (res_load) out_pend_q <= 1'b1;
			else if (out_move) out_pend_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid && !in_stall) state_q <= S_DIV_GO;
				S_DIV_GO: state_q <= S_DIV_WT;
				S_DIV_WT: if (div_done) begin
					idx_q   <= idx_q + 1'b1;
					state_q <= (idx_q == 2'd3) ? S_MIXA : S_DIV_GO;
				end
				S_MIXA: state_q <= S_MIXB;
				S_MIXB: if (res_load) begin
					state_q <= S_IDLE;
					for (int i = 0; i < 4; i++) motor_q[i] <= m_new[i];
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && !in_stall) item_q <= in_data;
		if (state_q == S_DIV_WT && div_done) cmd_q[idx_q] <= div_quot;
		if (state_q == S_MIXA) begin
			dr_q     <= stab ? 18'(s_dr) : a_dr;
			dp_q     <= stab ? 18'(s_dp) : a_dp;
			dy_q     <= stab ? 18'(s_dy) : a_dy;
			ail_q    <= 14'(s_ail);
			ele_q    <= 15'(s_ele);
			mix_en_q <= mix_en;
		end
		if (res_load) res_q <= res;
		if (out_move) out_q <= res_q;
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

`ifndef NO_ASSERTIONS
	a_start_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV_WT)
		else $error("divider finished outside the wait state");
	a_accept_go: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> state_q == S_DIV_GO)
		else $error("input transfer did not start the divisions");
	a_mix_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_MIXA |-> idx_q == 2'd0 && $past(div_done))
		else $error("mix entered before all stick commands were ready");
`endif

endmodule

[hw/rtl/hqpam_div.sv]
// ----------------------------------------------------------------------------
// hqpam_div: iterative signed divider
// Restoring divide, one quotient bit per cycle, truncates toward zero;
// a zero divisor gives a zero quotient.
// ----------------------------------------------------------------------------
module hqpam_div
	import hqpam_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic signed [NUM_W-1:0] num,
	input  logic signed [DEN_W-1:0] den,
	output logic                    done,
	output logic signed [NUM_W-1:0] quot
);

	logic              busy_q, done_q, neg_q, zero_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [QMAG_W-1:0] q_q;
	logic [DMAG_W-1:0] rem_q, dmag_q;
	logic [NUM_W-1:0]  nabs;
	logic [DEN_W-1:0]  dabs;
	logic [DMAG_W:0]   trial;
	logic              qbit;

	assign nabs  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign dabs  = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
	assign trial = {rem_q, q_q[QMAG_W-1]};
	assign qbit  = trial >= {1'b0, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_W'(QMAG_W - 1));
			if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(QMAG_W - 1)) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q    <= nabs[QMAG_W-1:0];
			dmag_q <= dabs[DMAG_W-1:0];
			rem_q  <= '0;
			neg_q  <= num[NUM_W-1] ^ den[DEN_W-1];
			zero_q <= (den == '0);
		end else if (busy_q) begin
			// shift the next dividend bit in, quotient bit out at the bottom
			rem_q <= qbit ? DMAG_W'(trial - {1'b0, dmag_q}) : trial[DMAG_W-1:0];
			q_q   <= {q_q[QMAG_W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quot = zero_q ? '0 :
		(neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q}));

endmodule

[verif/hybrid_quad_plane_attitude_mixer_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hybrid_quad_plane_attitude_mixer_unit_tb: self-checking bench for the mixer
// Drives control frames through several register settings, predicts the eight
// output channels per frame with a behavioral model and compares every field.
// ----------------------------------------------------------------------------
module hybrid_quad_plane_attitude_mixer_unit_tb;
	import hqpam_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int NUM_PHASES     = 11;

	logic            clk;
	logic            arst_n;
	logic            cfg_we;
	logic [2:0]      cfg_addr;
	logic [CH_W-1:0] cfg_data;
	logic            in_valid;
	logic            in_stall;
	in_t             in_data;
	logic            out_valid;
	logic            out_stall;
	out_t            out_data;

	hybrid_quad_plane_attitude_mixer_unit dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	// mirrored register file and motor state
	longint mode_reg, mixing_reg, st_min, st_mid, st_max, o_min, o_mid;
	longint motor_q4[4];

	in_t  frame_q[$];
	out_t channels_q[$];
	int   mismatches;
	int   idle_cycles;
	int   gap_left, burst_left, stall_left;
	bit   in_xfer;
	bit   out_xfer;
	bit   stimulus_done;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic longint floor_div(longint v, longint m);
		longint q;
		q = v / m;
		if (v % m != 0 && v < 0) q--;
		return q;
	endfunction

	function automatic longint clip(longint v, longint lim);
		return v > lim ? lim : (v < -lim ? -lim : v);
	endfunction

	function automatic logic [CH_W-1:0] to_channel(longint v);
		return v < 0 ? 12'd0 : (v > 4095 ? 12'd4095 : v[CH_W-1:0]);
	endfunction

	function automatic longint stick_q4(longint s, longint k);
		longint span;
		span = st_max - st_min;
		if (span == 0) return 0;
		return (32 * k * (s - st_mid)) / span;
	endfunction

	// channels for one frame; updates the stored motor commands
	function automatic out_t mix_frame(in_t f);
		out_t   r;
		longint thr, ail, ele, rud, arm, ap;
		longint roll, pitch, pr, qr, yr;
		longint mode, droll, dpitch, dyaw, t, a_cmd, e_cmd;
		thr = f.throttle_pw; ail = f.aileron_pw; ele = f.elevator_pw;
		rud = f.rudder_pw; arm = f.rx_arm; ap = f.autopilot_pw;
		roll = $signed(f.roll_angle); pitch = $signed(f.pitch_angle);
		pr = $signed(f.roll_dps); qr = $signed(f.pitch_dps); yr = $signed(f.yaw_dps);
		if (mixing_reg != 0) begin
			if (mode_reg < 0) mode = (ap > st_mid) ? -mode_reg : 0;
			else mode = mode_reg;
			if (mode == 0 || mode == 1) begin
				if (mode == 1) begin
					dyaw = -clip(50 * (yr - stick_q4(rud, 50)), 8000);
					droll = -clip(2 * (roll - stick_q4(ail, 30)) + 10 * pr, 8000);
					dpitch = clip(2 * (pitch + stick_q4(ele, 30)) + 10 * qr, 8000);
				end else begin
					droll = 16 * (ail - st_mid);
					dpitch = 16 * (ele - st_mid);
					dyaw = 16 * (rud - st_mid);
				end
				t = 16 * thr;
				motor_q4[0] = to_channel(floor_div(t - droll + dpitch + dyaw, 16));
				motor_q4[1] = to_channel(floor_div(t - droll - dpitch - dyaw, 16));
				motor_q4[2] = to_channel(floor_div(t + droll + dpitch - dyaw, 16));
				motor_q4[3] = to_channel(floor_div(t + droll - dpitch + dyaw, 16));
			end
			if (arm > st_mid) begin
				r.quad_ch1 = to_channel(motor_q4[0]);
				r.quad_ch2 = to_channel(motor_q4[1]);
				r.quad_ch3 = to_channel(motor_q4[2]);
				r.quad_ch4 = to_channel(motor_q4[3]);
				r.quad_ch5 = to_channel(arm);
			end else begin
				r.quad_ch1 = to_channel(o_min);
				r.quad_ch2 = to_channel(o_min);
				r.quad_ch3 = to_channel(o_min);
				r.quad_ch4 = to_channel(o_min);
				r.quad_ch5 = to_channel(o_min);
			end
		end else begin
			r.quad_ch1 = to_channel(thr);
			r.quad_ch2 = to_channel(ail);
			r.quad_ch3 = to_channel(ele);
			r.quad_ch4 = to_channel(rud);
			r.quad_ch5 = to_channel(arm);
		end
		a_cmd = clip(10 * (roll - stick_q4(ail, 50)) + 2 * pr, 8000);
		e_cmd = clip(20 * (pitch + stick_q4(ele, 30)) + qr, 16000);
		r.plane_aileron = to_channel(floor_div(-a_cmd, 16) + o_mid);
		r.plane_elevator = to_channel(floor_div(e_cmd, 32) + o_mid);
		r.plane_rudder = to_channel(floor_div(a_cmd, 16) + o_mid);
		return r;
	endfunction

	function automatic logic [CH_W-1:0] rand_stick();
		if ($urandom_range(0, 4) == 0) return CH_W'($urandom_range(0, 4095));
		return CH_W'($urandom_range(850, 2150));
	endfunction

	function automatic logic [ATT_W-1:0] rand_att();
		if ($urandom_range(0, 4) == 0) return ATT_W'($urandom_range(0, 65535));
		return ATT_W'($urandom_range(0, 1600) - 800);
	endfunction

	function automatic in_t rand_frame();
		in_t f;
		f.throttle_pw = rand_stick();
		f.aileron_pw = rand_stick();
		f.elevator_pw = rand_stick();
		f.rudder_pw = rand_stick();
		if ($urandom_range(0, 3) != 0) f.rx_arm = CH_W'($urandom_range(1600, 4095));
		else f.rx_arm = CH_W'($urandom_range(0, 1600));
		f.autopilot_pw = $urandom_range(0, 1) ? 12'(st_mid + 1) : 12'($urandom_range(0, 4095));
		f.roll_angle = rand_att();
		f.pitch_angle = rand_att();
		f.roll_dps = rand_att();
		f.pitch_dps = rand_att();
		f.yaw_dps = rand_att();
		return f;
	endfunction

	task automatic write_reg(logic [2:0] idx, longint v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= v[CH_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_CONTROL_MODE:   mode_reg = v[2] ? (v & 7) - 8 : (v & 7);
			REG_ONBOARD_MIXING: mixing_reg = v & 1;
			REG_STICK_MIN:      st_min = v & 12'hFFF;
			REG_STICK_MID:      st_mid = v & 12'hFFF;
			REG_STICK_MAX:      st_max = v & 12'hFFF;
			REG_OUT_MIN:        o_min = v & 12'hFFF;
			REG_OUT_MID:        o_mid = v & 12'hFFF;
			default: ;
		endcase
	endtask

	// hold off until every frame is sent and every result has come back
	task automatic drain();
		while (frame_q.size() != 0 || in_valid || channels_q.size() != 0)
			@(posedge clk);
		repeat (130) @(posedge clk);
	endtask

	initial begin
		int   modes[NUM_PHASES] = '{0, 1, 0, -1, 2, -3, -4, 1, 1, -2, 3};
		int   mixes[NUM_PHASES] = '{0, 1, 1, 1, 1, 1, 1, 1, 1, 0, 1};
		int   smins[NUM_PHASES] = '{992, 992, 992, 992, 992, 992, 1000, 2016, 0, 4095, 1000};
		int   smids[NUM_PHASES] = '{1504, 1504, 1504, 1504, 1504, 1504, 1500, 1504, 0,
			4095, 1500};
		int   smaxs[NUM_PHASES] = '{2016, 2016, 2016, 2016, 2016, 2016, 1000, 992, 4095, 0,
			2000};
		int   omins[NUM_PHASES] = '{992, 992, 992, 992, 992, 992, 0, 4095, 0, 4095, 500};
		int   omids[NUM_PHASES] = '{1504, 1504, 1504, 1504, 1504, 1504, 4095, 0, 0, 4095,
			2000};
		in_t  f;
		mode_reg = 0; mixing_reg = 0; st_min = 992; st_mid = 1504; st_max = 2016;
		o_min = 992; o_mid = 1504;
		for (int i = 0; i < 4; i++) motor_q4[i] = 0;
		stimulus_done = 0;
		cfg_we = 1'b0;
		cfg_addr = REG_CONTROL_MODE;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p > 0) begin
				write_reg(REG_CONTROL_MODE, modes[p]);
				write_reg(REG_ONBOARD_MIXING, mixes[p]);
				write_reg(REG_STICK_MIN, smins[p]);
				write_reg(REG_STICK_MID, smids[p]);
				write_reg(REG_STICK_MAX, smaxs[p]);
				write_reg(REG_OUT_MIN, omins[p]);
				write_reg(REG_OUT_MID, omids[p]);
			end
			if (p == 1) begin
				// field extremes, arm and autopilot right at the threshold
				for (int d = 0; d < 20; d++) begin
					f = rand_frame();
					case (d % 5)
						0: f = '0;
						1: f = '1;
						2: begin
							f.roll_angle = 16'sh8000; f.pitch_angle = 16'sh7FFF;
							f.roll_dps = 16'sh7FFF; f.pitch_dps = 16'sh8000;
							f.yaw_dps = 16'sh8000;
						end
						3: begin
							f.rx_arm = 12'(st_mid); f.autopilot_pw = 12'(st_mid);
						end
						default: begin
							f.rx_arm = 12'(st_mid + 1); f.throttle_pw = 12'd4095;
							f.aileron_pw = '0; f.elevator_pw = 12'd4095; f.rudder_pw = '0;
						end
					endcase
					frame_q.push_back(f);
				end
			end
			for (int n = 0; n < 110; n++) frame_q.push_back(rand_frame());
			drain();
		end
		stimulus_done = 1;
	end

	// sender: bursts separated by random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			gap_left = 0;
			burst_left = 0;
		end else if (!in_valid || in_xfer) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (frame_q.size() != 0) begin
				in_data <= frame_q.pop_front();
				in_valid <= 1'b1;
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 8);
					gap_left = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 220) : 0;
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: stretches of no stall mixed with stalls of random length
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
		end else if ($urandom_range(0, 2) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(1, 150);
		end else begin
			out_stall <= 1'b0;
			stall_left = $urandom_range(1, 400);
		end
	end

	// accept, predict and check
	always @(posedge clk) begin
		out_t want;
		string names[8] = '{"quad_ch1", "quad_ch2", "quad_ch3", "quad_ch4", "quad_ch5",
			"plane_aileron", "plane_elevator", "plane_rudder"};
		in_xfer = arst_n && in_valid && !in_stall;
		out_xfer = arst_n && out_valid && !out_stall;
		if (in_xfer) channels_q.push_back(mix_frame(in_data));
		if (out_xfer) begin
			if (channels_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected transfer: %h", out_data);
			end else begin
				want = channels_q.pop_front();
				for (int c = 0; c < 8; c++) begin
					if (want[95-12*c -: 12] !== out_data[95-12*c -: 12]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%s: expected %0d got %0d", names[c],
								want[95-12*c -: 12], out_data[95-12*c -: 12]);
					end
				end
			end
		end
	end

	// watchdog and end of run
	always @(posedge clk) begin
		if (in_xfer || out_xfer || (frame_q.size() == 0 && !in_valid && channels_q.size() == 0))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else if (stimulus_done) begin
			if (mismatches == 0 && channels_q.size() == 0)
				$display("CHECK OK");
			else
				$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		mismatches = 0;
		idle_cycles = 0;
		in_xfer = 0;
		out_xfer = 0;
	end

endmodule

[filelist.f]
hw/rtl/hqpam_pkg.sv
hw/rtl/hqpam_div.sv
hw/rtl/hybrid_quad_plane_attitude_mixer_unit.sv
verif/hybrid_quad_plane_attitude_mixer_unit_tb.sv
